@@ rtl/aob_pkg.sv @@
// ----------------------------------------------------------------------------
// aob_pkg
// types, action codes and cosine table arithmetic for the oscillator bank
// ----------------------------------------------------------------------------
package aob_pkg;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_PUSH  = 3'd1;
   localparam logic [2:0] ACT_POP   = 3'd2;
   localparam logic [2:0] ACT_CLEAR = 3'd3;
   localparam logic [2:0] ACT_RESET = 3'd4;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint ONE_Q30 = 64'sd1073741824;

   typedef struct packed {
      logic [2:0]         action;
      logic [31:0]        phase_step;
      logic signed [15:0] gain;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               saturated;
      logic [4:0]         voice_total;
      logic               rejected;
   } rsp_type;

   // unsigned quotient by shift and subtract, evaluated at elaboration only
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quarter-wave cosine entry in Q1.15, taylor series over eight terms
   function automatic logic [14:0] quarter_cos(input int m, input int lut_bits);
      longint unsigned x;
      longint unsigned term;
      longint unsigned dvs;
      longint sum;
      longint v;
      x = (longint'(m) * TWO_PI_Q30 + (64'd1 << (lut_bits - 1))) >> lut_bits;
      term = 64'd1 << 30;
      sum = ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         dvs = longint'((2 * n - 1) * (2 * n));
         term = udiv64(term, dvs);
         if (n[0] == 1'b1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32767) begin
         v = 32767;
      end
      return v[14:0];
   endfunction

endpackage

@@ rtl/aob_stream_if.sv @@
// ----------------------------------------------------------------------------
// aob_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface aob_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/additive_oscillator_bank.sv @@
// ----------------------------------------------------------------------------
// additive_oscillator_bank
// Bank of up to MAX_VOICES cosine oscillators summed into one Q1.15 sample.
// Every request transaction yields exactly one response transaction. Push, pop,
// clear and unused actions are answered directly: the response is registered at
// acceptance, and the next request can follow in the next cycle if that
// response is taken. A tick walks the active voices through one shared gain
// multiplier, one voice per cycle, through memory read, cosine rom read,
// multiply and accumulate, then rounds and clips the sum for the response.
// A phase reset sweeps the phase memory one voice per cycle.
// The block takes no new request while a tick or a phase reset is in progress.
// ----------------------------------------------------------------------------
module additive_oscillator_bank #(
   parameter int MAX_VOICES = 16,
   parameter int LUT_BITS   = 10,
   parameter int PHASE_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   aob_stream_if.sink   req,
   aob_stream_if.source rsp
);

   localparam int IDX_W    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W    = $clog2(MAX_VOICES + 1);
   localparam int ACC_W    = 32 + $clog2(MAX_VOICES + 1);
   localparam int QTR_SIZE = 1 << (LUT_BITS - 2);
   localparam int QA_W     = LUT_BITS - 1;
   localparam int EXT_W    = (PHASE_BITS > 32) ? PHASE_BITS : 32;

   typedef logic [14:0] rom_type [QTR_SIZE + 1];

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TICK   = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   function automatic rom_type build_rom();
      rom_type t;
      for (int m = 0; m <= QTR_SIZE; m++) begin
         t[m] = aob_pkg::quarter_cos(m, LUT_BITS);
      end
      return t;
   endfunction

   localparam rom_type QTR_ROM = build_rom();

   // voice memories
   logic [PHASE_BITS-1:0]  voice_phase_ff [MAX_VOICES];
   logic [PHASE_BITS-1:0]  voice_step_ff  [MAX_VOICES];
   logic signed [15:0]     voice_gain_ff  [MAX_VOICES];

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   is_tick_ff, is_tick_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   aob_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic [PHASE_BITS-1:0]  phase_rd_ff;
   logic [PHASE_BITS-1:0]  step_rd_ff;
   logic signed [15:0]     gain_rd_ff;
   logic [14:0]            rom_ff;
   logic                   neg_ff;
   logic signed [15:0]     gain2_ff;
   logic signed [31:0]     prod_ff;

   logic                   req_ready;
   logic                   accept;
   logic                   issue;
   logic                   rej;
   logic                   one_cycle;
   logic [IDX_W-1:0]       rd_addr;
   logic                   ph_we;
   logic [IDX_W-1:0]       ph_waddr;
   logic [PHASE_BITS-1:0]  ph_wdata;
   logic                   sg_we;
   logic [EXT_W-1:0]       step_ext;
   logic [PHASE_BITS-1:0]  step_wr;
   logic [PHASE_BITS-1:0]  next_phase;
   logic [LUT_BITS-1:0]    lut_idx;
   logic [1:0]             quad;
   logic [QA_W-1:0]        rem_ext;
   logic [QA_W-1:0]        rom_addr;
   logic signed [15:0]     cos_val;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] shifted;
   logic                   sat_hi, sat_lo;
   logic signed [15:0]     sample_val;

   assign accept    = req.valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   assign step_ext   = EXT_W'(req.payload.phase_step);
   assign step_wr    = step_ext[PHASE_BITS-1:0];
   assign next_phase = phase_rd_ff + step_rd_ff;

   // cosine lookup by quarter-wave symmetry
   assign lut_idx  = phase_rd_ff[PHASE_BITS-1 -: LUT_BITS];
   assign quad     = lut_idx[LUT_BITS-1 -: 2];
   assign rem_ext  = {1'b0, lut_idx[LUT_BITS-3:0]};
   assign rom_addr = quad[0] ? (QA_W'(QTR_SIZE) - rem_ext) : rem_ext;
   assign cos_val  = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

   // round to nearest, ties toward plus infinity, then clip
   assign rnd        = acc_ff + ACC_W'(16384);
   assign shifted    = rnd >>> 15;
   assign sat_hi     = shifted > 32767;
   assign sat_lo     = shifted < -32768;
   assign sample_val = sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : shifted[15:0]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      is_tick_in   = is_tick_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      issue        = 1'b0;
      rej          = 1'b0;
      one_cycle    = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];
      ph_we        = 1'b0;
      ph_waddr     = s1_idx_ff;
      ph_wdata     = next_phase;
      sg_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = '0;
               acc_in    = '0;
               one_cycle = 1'b1;
               case (req.payload.action)
                  aob_pkg::ACT_TICK: begin
                     state_in   = ST_TICK;
                     is_tick_in = 1'b1;
                     one_cycle  = 1'b0;
                  end
                  aob_pkg::ACT_PUSH: begin
                     if (count_ff == CNT_W'(MAX_VOICES)) begin
                        rej = 1'b1;
                     end else begin
                        ph_we    = 1'b1;
                        ph_waddr = count_ff[IDX_W-1:0];
                        ph_wdata = '0;
                        sg_we    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  aob_pkg::ACT_POP: begin
                     if (count_ff == '0) begin
                        rej = 1'b1;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  aob_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  aob_pkg::ACT_RESET: begin
                     state_in   = ST_SWEEP;
                     is_tick_in = 1'b0;
                     one_cycle  = 1'b0;
                  end
                  default: begin
                  end
               endcase
               if (one_cycle) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in                = '0;
                  rsp_in.voice_total    = 5'(count_in);
                  rsp_in.rejected       = rej;
               end
            end
         end
         ST_TICK: begin
            ph_we = s1_vld_ff;
            if (s3_vld_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if (idx_ff < count_ff) begin
               issue  = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end else if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            if (idx_ff < count_ff) begin
               ph_we    = 1'b1;
               ph_waddr = idx_ff[IDX_W-1:0];
               ph_wdata = '0;
               idx_in   = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.voice_total = 5'(count_ff);
               if (is_tick_ff) begin
                  rsp_in.sample    = sample_val;
                  rsp_in.saturated = sat_hi || sat_lo;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= issue;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      is_tick_ff <= is_tick_in;
      acc_ff     <= acc_in;
      rsp_ff     <= rsp_in;
      s1_idx_ff  <= rd_addr;
      rom_ff     <= QTR_ROM[rom_addr];
      neg_ff     <= quad[1] ^ quad[0];
      gain2_ff   <= gain_rd_ff;
      prod_ff    <= gain2_ff * cos_val;
   end

   // phase memory
   always_ff @(posedge clock) begin
      if (ph_we) begin
         voice_phase_ff[ph_waddr] <= ph_wdata;
      end
      phase_rd_ff <= voice_phase_ff[rd_addr];
   end

   // step and gain memories
   always_ff @(posedge clock) begin
      if (sg_we) begin
         voice_step_ff[count_ff[IDX_W-1:0]] <= step_wr;
         voice_gain_ff[count_ff[IDX_W-1:0]] <= req.payload.gain;
      end
      step_rd_ff <= voice_step_ff[rd_addr];
      gain_rd_ff <= voice_gain_ff[rd_addr];
   end

`ifndef ASSERT_OFF
   a_pipe_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff || s3_vld_ff) |-> (state_ff == ST_TICK))
      else $error("voice pipeline busy outside tick");

   a_count_changes_on_accept: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(req.valid && req.ready))
      else $error("voice count changed without a transaction");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not delivered");

   a_full_push_rejected: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.payload.action == aob_pkg::ACT_PUSH
       && count_ff == CNT_W'(MAX_VOICES))
      |=> (rsp_valid_ff && rsp_ff.rejected && count_ff == $past(count_ff)))
      else $error("push on full bank not rejected");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for additive_oscillator_bank. A queue of requests is
// built up front: a short directed opening, then random segments that push
// voices, tick the bank amid mixed commands, then clear it, pop or keep it. The
// driver plays the queue with random idle bursts. Each accepted request is
// run through a bit-accurate model of the bank: cosine quarter table, Q30
// accumulation, rounding and clipping. The monitor checks every response
// against the oldest predicted one, with random backpressure on its side.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         VOICE_MAX     = 16;
   localparam int         QTR_LEN       = 256;
   localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
   localparam int         RANDOM_ITEMS  = 950;
   localparam int         WIND_DOWN     = 120;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES  = 40;

   logic clock;
   logic reset;

   aob_stream_if #(.payload_type(aob_pkg::req_type)) req_if ();
   aob_stream_if #(.payload_type(aob_pkg::rsp_type)) rsp_if ();

   additive_oscillator_bank dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // model state
   int          cos_quarter [0:QTR_LEN];
   logic [31:0] osc_phase [VOICE_MAX];
   logic [31:0] osc_step [VOICE_MAX];
   int          osc_gain [VOICE_MAX];
   int unsigned live_voices;

   aob_pkg::req_type pending_req [$];
   aob_pkg::rsp_type expected_rsp [$];
   int          stim_count;
   int          error_count;
   int          tick_count;
   int          clip_count;
   int          push_count;
   int          reject_count;

   int          req_gap;
   int          rsp_stall;
   bit          req_lazy;
   bit          rsp_lazy;
   bit          wind_down;
   int          quiet_cycles;

   function automatic int quarter_wave(int unsigned m);
      longint unsigned ang;
      longint unsigned t;
      longint          s;
      longint          v;
      ang = (longint'(m) * aob_pkg::TWO_PI_Q30 + 64'd512) >> 10;
      t = 64'd1 << 30;
      s = aob_pkg::ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         t = (t * ang) >> 30;
         t = (t * ang) >> 30;
         t = t / longint'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > aob_pkg::ONE_Q30) begin
         s = aob_pkg::ONE_Q30;
      end
      v = (s + 16384) >>> 15;
      if (v > 32767) begin
         v = 32767;
      end
      return int'(v);
   endfunction

   function automatic int wave_at(logic [31:0] ph);
      logic [9:0] idx;
      idx = ph[31:22];
      case (idx[9:8])
         2'd0: return cos_quarter[idx[7:0]];
         2'd1: return -cos_quarter[QTR_LEN - idx[7:0]];
         2'd2: return -cos_quarter[idx[7:0]];
         default: return cos_quarter[QTR_LEN - idx[7:0]];
      endcase
   endfunction

   function automatic aob_pkg::rsp_type bank_step(aob_pkg::req_type item);
      aob_pkg::rsp_type r;
      longint  total;
      r = '0;
      case (item.action)
         aob_pkg::ACT_TICK: begin
            total = 0;
            for (int i = 0; i < live_voices; i++) begin
               total += longint'(osc_gain[i]) * longint'(wave_at(osc_phase[i]));
            end
            total = (total + 16384) >>> 15;
            if (total > 32767) begin
               total = 32767;
               r.saturated = 1'b1;
            end else if (total < -32768) begin
               total = -32768;
               r.saturated = 1'b1;
            end
            r.sample = total[15:0];
            for (int i = 0; i < live_voices; i++) begin
               osc_phase[i] = osc_phase[i] + osc_step[i];
            end
            tick_count++;
            clip_count += r.saturated;
         end
         aob_pkg::ACT_PUSH: begin
            if (live_voices >= VOICE_MAX) begin
               r.rejected = 1'b1;
            end else begin
               osc_phase[live_voices] = '0;
               osc_step[live_voices] = item.phase_step;
               osc_gain[live_voices] = item.gain;
               live_voices++;
               push_count++;
            end
         end
         aob_pkg::ACT_POP: begin
            if (live_voices == 0) begin
               r.rejected = 1'b1;
            end else begin
               live_voices--;
            end
         end
         aob_pkg::ACT_CLEAR: begin
            live_voices = 0;
         end
         aob_pkg::ACT_RESET: begin
            for (int i = 0; i < live_voices; i++) begin
               osc_phase[i] = '0;
            end
         end
         default: begin
         end
      endcase
      r.voice_total = live_voices[4:0];
      reject_count += r.rejected;
      return r;
   endfunction

   task automatic queue_request(logic [2:0] act, logic [31:0] step, logic signed [15:0] g);
      aob_pkg::req_type item;
      item.action = act;
      item.phase_step = step;
      item.gain = g;
      pending_req.insert(pending_req.size(), item);
      stim_count++;
   endtask

   function automatic logic [31:0] random_step();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0040_0000);
         2: return 32'd1 << $urandom_range(0, 31);
         default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
   endfunction

   function automatic logic signed [15:0] random_gain(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(24000, 32767));
         2: return 16'(-$signed($urandom_range(24000, 32768)));
         default: return 16'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_req.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.payload <= pending_req.pop_front();
            if (!wind_down && req_lazy && $urandom_range(0, 3) == 0) begin
               req_gap <= $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      if ($urandom_range(0, 39) == 0) begin
         req_lazy <= ~req_lazy;
      end
      wind_down <= pending_req.size() < WIND_DOWN;
   end

   // response ready with stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!wind_down && rsp_lazy && $urandom_range(0, 3) == 0) begin
            rsp_stall <= $urandom_range(1, 8);
         end
      end
      if ($urandom_range(0, 39) == 0) begin
         rsp_lazy <= ~rsp_lazy;
      end
   end

   // monitor: check responses, then predict from accepted requests
   always @(posedge clock) begin
      aob_pkg::rsp_type want;
      aob_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.payload;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response transaction sample=%0d sat=%0b total=%0d rej=%0b",
                        $time, got.sample, got.saturated, got.voice_total, got.rejected);
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected sample=%0d sat=%0b total=%0d rej=%0b",
                           $time, want.sample, want.saturated, want.voice_total, want.rejected);
                  $display("%0t:          actual   sample=%0d sat=%0b total=%0d rej=%0b",
                           $time, got.sample, got.saturated, got.voice_total, got.rejected);
                  error_count++;
               end
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            expected_rsp.insert(expected_rsp.size(), bank_step(req_if.payload));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("additive_oscillator_bank test failed");
            $finish;
         end
      end
   end

   initial begin
      int mode;
      int pick;
      int target;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      reset = 1'b1;
      req_lazy = 1'b1;
      rsp_lazy = 1'b0;
      wind_down = 1'b0;
      quiet_cycles = 0;
      live_voices = 0;
      stim_count = 0;
      error_count = 0;
      tick_count = 0;
      clip_count = 0;
      push_count = 0;
      reject_count = 0;
      for (int m = 0; m <= QTR_LEN; m++) begin
         cos_quarter[m] = quarter_wave(m);
      end

      // directed opening on an empty bank
      queue_request(aob_pkg::ACT_POP, '0, '0);
      queue_request(aob_pkg::ACT_CLEAR, '0, '0);
      queue_request(aob_pkg::ACT_TICK, '0, '0);
      for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
         queue_request(3'(a), 32'hFFFF_FFFF, 16'sh7FFF);
      end
      // fill to the top with extreme gains and steps
      queue_request(aob_pkg::ACT_PUSH, 32'h0000_0000, 16'sh7FFF);
      queue_request(aob_pkg::ACT_PUSH, 32'hFFFF_FFFF, -16'sh8000);
      for (int v = 2; v < VOICE_MAX; v++) begin
         queue_request(aob_pkg::ACT_PUSH, 32'd1 << (v + 16), -16'sh8000);
      end
      queue_request(aob_pkg::ACT_PUSH, 32'h1234_5678, 16'sh1000);
      queue_request(aob_pkg::ACT_TICK, '0, '0);
      queue_request(aob_pkg::ACT_TICK, '0, '0);
      queue_request(aob_pkg::ACT_RESET, '0, '0);
      queue_request(aob_pkg::ACT_TICK, '0, '0);
      queue_request(aob_pkg::ACT_CLEAR, '0, '0);

      // random segments: push, exercise, then clear, pop or keep
      while (stim_count < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 3);
         target = $urandom_range(0, VOICE_MAX + 1);
         repeat (target) begin
            queue_request(aob_pkg::ACT_PUSH, random_step(), random_gain(mode));
         end
         repeat ($urandom_range(4, 24)) begin
            pick = $urandom_range(0, 99);
            if (pick < 64) begin
               queue_request(aob_pkg::ACT_TICK, $urandom, 16'($urandom));
            end else if (pick < 74) begin
               queue_request(aob_pkg::ACT_PUSH, random_step(), random_gain(mode));
            end else if (pick < 84) begin
               queue_request(aob_pkg::ACT_POP, $urandom, 16'($urandom));
            end else if (pick < 91) begin
               queue_request(aob_pkg::ACT_RESET, $urandom, 16'($urandom));
            end else if (pick < 95) begin
               queue_request(aob_pkg::ACT_CLEAR, $urandom, 16'($urandom));
            end else begin
               queue_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom,
                             16'($urandom));
            end
         end
         case ($urandom_range(0, 2))
            0: queue_request(aob_pkg::ACT_CLEAR, '0, '0);
            1: repeat ($urandom_range(1, VOICE_MAX + 1)) queue_request(aob_pkg::ACT_POP, '0, '0);
            default: begin
            end
         endcase
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_if.valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d ticks (%0d clipped), %0d voices pushed",
               stim_count, tick_count, clip_count, push_count);
      $display("%0d rejected push/pop requests, %0d errors", reject_count, error_count);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("additive_oscillator_bank test passed");
      end else begin
         $display("additive_oscillator_bank test failed");
      end
      $finish;
   end

endmodule
